// ===== rtl/kvct_pkg.sv =====
// types, character codes and sizes shared by the key/value tokenizer
`default_nettype none

package kvct_pkg;

	localparam int MAX_TOKEN_LEN = 1024;
	localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 2);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;

	typedef enum logic [1:0] {
		ST_BLANK,
		ST_COMMENT,
		ST_WORD,
		ST_STRING
	} lex_state_t;

	typedef enum logic [1:0] {
		K_WORD,
		K_STRING,
		K_EQUAL,
		K_SEMI
	} kind_t;

	typedef enum logic [1:0] {
		GP_KEY,
		GP_EQUAL,
		GP_VALUE,
		GP_SEMI
	} gpos_t;

	typedef struct packed {
		kind_t      token_kind;
		logic [7:0] content_byte;
		logic       byte_valid;
		logic       token_end;
		logic       too_long;
		logic       statement_done;
		logic       syntax_error;
		logic       last;
	} res_t;

	typedef struct packed {
		gpos_t pos;
		logic  done;
		logic  err;
	} gram_t;

	typedef struct packed {
		logic             emit;
		res_t             res;
		lex_state_t       state;
		logic             quote;
		logic [LEN_W-1:0] len;
		gpos_t            pos;
		logic             err;
	} blank_t;

endpackage

`default_nettype wire

// ===== rtl/key_value_config_tokenizer_core.sv =====
// top level: byte-stream lexer for key/value text with grammar checker and result queue
//
// Takes one text byte per beat and can accept a beat on every cycle. A byte goes
// into an input register, is lexed and checked combinationally, and its zero, one or
// two result beats land in a four-slot result queue; the head of the queue is offered
// at the output. A byte that closes a word with '=' or ';',
// or an end-of-input beat that closes an open token, makes two result beats. The
// input side stalls only while the queue has fewer than two free slots, so with
// the output always ready a byte is taken every cycle while each byte makes at
// most one beat, while two-beat bytes can make the input stall. Tokens longer
// than MAX_TOKEN_LEN bytes drop the extra bytes and flag too_long on the closing
// beat. The syntax error flag is sticky until an end-of-input beat reports it.
`default_nettype none

module key_value_config_tokenizer_core
	import kvct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  wire logic [0:0]  s_axis_tuser,  // [0] end_of_input
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [15:0] m_axis_tdata,  // [7:0] content_byte, [8] byte_valid,
	                                        // [9] token_end, [10] too_long,
	                                        // [11] statement_done, [12] syntax_error
	output      logic [1:0]  m_axis_tuser,  // [1:0] token_kind
	output      logic        m_axis_tlast
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eoi_s1;

	lex_state_t       lex_q, lex_d;
	logic             quote_q, quote_d;
	logic [LEN_W-1:0] len_q, len_d;
	gpos_t            gpos_q, gpos_d;
	logic             err_q, err_d;

	res_t             queue_q [Q_DEPTH];
	logic [Q_AW-1:0]  wptr_q, rptr_q;
	logic [Q_CW-1:0]  count_q;

	res_t             r0, r1, rep, head;
	logic [1:0]       n;
	gram_t            ga;
	blank_t           bo;
	logic             end_err;
	logic             fire, pop, s_acc;

	function automatic gram_t gram(input gpos_t pos, input kind_t kind, input logic err);
		gram_t g;
		logic  ok;
		unique case (pos)
			GP_KEY:   ok = (kind == K_WORD);
			GP_EQUAL: ok = (kind == K_EQUAL);
			GP_VALUE: ok = (kind == K_WORD) || (kind == K_STRING);
			GP_SEMI:  ok = (kind == K_SEMI);
			default:  ok = 1'b0;
		endcase
		if (ok) begin
			g.pos  = gpos_t'(pos + 2'd1);
			g.done = (pos == GP_SEMI);
			g.err  = err;
		end else begin
			g.pos  = (kind == K_SEMI) ? GP_KEY : pos;
			g.done = 1'b0;
			g.err  = 1'b1;
		end
		return g;
	endfunction

	function automatic logic is_space(input logic [7:0] ch);
		return (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
	endfunction

	function automatic res_t close_res(input kind_t kind, input logic [LEN_W-1:0] len,
			input gram_t g);
		res_t r;
		r                = '0;
		r.token_kind     = kind;
		r.token_end      = 1'b1;
		r.too_long       = (len > LEN_W'(MAX_TOKEN_LEN));
		r.statement_done = g.done;
		r.syntax_error   = g.err;
		return r;
	endfunction

	function automatic blank_t blank_fn(input logic [7:0] ch, input gpos_t pos,
			input logic err, input logic quote);
		blank_t b;
		gram_t  g;
		kind_t  kind;
		b       = '0;
		b.state = ST_BLANK;
		b.quote = quote;
		b.pos   = pos;
		b.err   = err;
		kind    = (ch == CH_EQ) ? K_EQUAL : K_SEMI;
		g       = gram(pos, kind, err);
		if (ch == CH_HASH) begin
			b.state = ST_COMMENT;
		end else if (is_space(ch)) begin
			b.state = ST_BLANK;
		end else if ((ch == CH_EQ) || (ch == CH_SEMI)) begin
			b.emit                 = 1'b1;
			b.res.token_kind       = kind;
			b.res.content_byte     = ch;
			b.res.byte_valid       = 1'b1;
			b.res.token_end        = 1'b1;
			b.res.statement_done   = g.done;
			b.res.syntax_error     = g.err;
			b.pos                  = g.pos;
			b.err                  = g.err;
		end else if ((ch == CH_DQ) || (ch == CH_SQ)) begin
			b.state = ST_STRING;
			b.quote = (ch == CH_SQ);
		end else begin
			b.state              = ST_WORD;
			b.len                = LEN_W'(1);
			b.emit               = 1'b1;
			b.res.token_kind     = K_WORD;
			b.res.content_byte   = ch;
			b.res.byte_valid     = 1'b1;
			b.res.syntax_error   = err;
		end
		return b;
	endfunction

	// handshake
	assign fire          = valid_s1 && (count_q <= Q_CW'(Q_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || fire;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			byte_s1 <= s_axis_tdata;
			eoi_s1  <= s_axis_tuser[0];
		end
	end

	// lexer and grammar step
	always_comb begin
		r0      = '0;
		r1      = '0;
		rep     = '0;
		n       = 2'd0;
		ga      = '0;
		bo      = '0;
		end_err = err_q;
		lex_d   = lex_q;
		quote_d = quote_q;
		len_d   = len_q;
		gpos_d  = gpos_q;
		err_d   = err_q;
		if (eoi_s1) begin
			ga = gram(gpos_q, (lex_q == ST_STRING) ? K_STRING : K_WORD,
				err_q | (lex_q == ST_STRING));
			if ((lex_q == ST_WORD) || (lex_q == ST_STRING)) begin
				r0      = close_res((lex_q == ST_STRING) ? K_STRING : K_WORD, len_q, ga);
				n       = 2'd1;
				end_err = ga.err | (ga.pos != GP_KEY);
			end else begin
				end_err = err_q | (gpos_q != GP_KEY);
			end
			rep.syntax_error = end_err;
			if (n == 2'd1) begin
				r1 = rep;
			end else begin
				r0 = rep;
			end
			n       = n + 2'd1;
			lex_d   = ST_BLANK;
			quote_d = 1'b0;
			len_d   = '0;
			gpos_d  = GP_KEY;
			err_d   = 1'b0;
		end else begin
			unique case (lex_q)
				ST_BLANK: begin
					bo      = blank_fn(byte_s1, gpos_q, err_q, quote_q);
					r0      = bo.res;
					n       = {1'b0, bo.emit};
					lex_d   = bo.state;
					quote_d = bo.quote;
					len_d   = bo.len;
					gpos_d  = bo.pos;
					err_d   = bo.err;
				end
				ST_COMMENT: begin
					if (byte_s1 == CH_LF) begin
						lex_d = ST_BLANK;
					end
				end
				ST_WORD: begin
					if (is_space(byte_s1) || (byte_s1 == CH_EQ) || (byte_s1 == CH_SEMI)) begin
						ga      = gram(gpos_q, K_WORD, err_q);
						r0      = close_res(K_WORD, len_q, ga);
						bo      = blank_fn(byte_s1, ga.pos, ga.err, quote_q);
						r1      = bo.res;
						n       = bo.emit ? 2'd2 : 2'd1;
						lex_d   = ST_BLANK;
						len_d   = '0;
						gpos_d  = bo.pos;
						err_d   = bo.err;
					end else if (len_q < LEN_W'(MAX_TOKEN_LEN)) begin
						r0.token_kind   = K_WORD;
						r0.content_byte = byte_s1;
						r0.byte_valid   = 1'b1;
						r0.syntax_error = err_q;
						n               = 2'd1;
						len_d           = len_q + LEN_W'(1);
					end else begin
						len_d = LEN_W'(MAX_TOKEN_LEN + 1);
					end
				end
				ST_STRING: begin
					if ((!quote_q && (byte_s1 == CH_DQ)) || (quote_q && (byte_s1 == CH_SQ))) begin
						ga     = gram(gpos_q, K_STRING, err_q);
						r0     = close_res(K_STRING, len_q, ga);
						n      = 2'd1;
						lex_d  = ST_BLANK;
						len_d  = '0;
						gpos_d = ga.pos;
						err_d  = ga.err;
					end else if (len_q < LEN_W'(MAX_TOKEN_LEN)) begin
						r0.token_kind   = K_STRING;
						r0.content_byte = byte_s1;
						r0.byte_valid   = 1'b1;
						r0.syntax_error = err_q;
						n               = 2'd1;
						len_d           = len_q + LEN_W'(1);
					end else begin
						len_d = LEN_W'(MAX_TOKEN_LEN + 1);
					end
				end
				default: begin
					lex_d = ST_BLANK;
				end
			endcase
		end
		r0.last = (n == 2'd1);
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q   <= ST_BLANK;
			quote_q <= 1'b0;
			len_q   <= '0;
			gpos_q  <= GP_KEY;
			err_q   <= 1'b0;
		end else if (fire) begin
			lex_q   <= lex_d;
			quote_q <= quote_d;
			len_q   <= len_d;
			gpos_q  <= gpos_d;
			err_q   <= err_d;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (fire && (n != 2'd0)) begin
			queue_q[wptr_q] <= r0;
		end
		if (fire && (n == 2'd2)) begin
			queue_q[wptr_q + Q_AW'(1)] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (fire) begin
				wptr_q <= wptr_q + Q_AW'(n);
			end
			if (pop) begin
				rptr_q <= rptr_q + Q_AW'(1);
			end
			count_q <= count_q + (fire ? Q_CW'(n) : '0) - Q_CW'(pop);
		end
	end

	assign head          = queue_q[rptr_q];
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tuser  = head.token_kind;
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {3'b000, head.syntax_error, head.statement_done, head.too_long,
		head.token_end, head.byte_valid, head.content_byte};

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CW'(Q_DEPTH))
		else $error("result queue overflow");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_TOKEN_LEN + 1))
		else $error("token length past saturation");

	a_blank_len: assert property (@(posedge clk) disable iff (!arst_n)
		((lex_q == ST_BLANK) || (lex_q == ST_COMMENT)) |-> (len_q == '0))
		else $error("length not cleared outside a token");

	a_eoi_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && eoi_s1) |=> ((lex_q == ST_BLANK) && (gpos_q == GP_KEY) && !err_q))
		else $error("end of input did not restore state");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q && !(fire && eoi_s1)) |=> err_q)
		else $error("syntax error cleared without end of input");

endmodule

`default_nettype wire
